/* rtl/core/tlf_pkg.sv */
`timescale 1ns / 1ps

package tlf_pkg;

    // seven-bit codes after the parity bit is cleared
    localparam logic [6:0] BYTE_MASK = 7'h7f;
    localparam logic [6:0] CODE_STX  = 7'h02;
    localparam logic [6:0] CODE_ETX  = 7'h03;
    localparam logic [6:0] CODE_CR   = 7'h0d;
    localparam logic [6:0] CODE_LF   = 7'h0a;

    // separator and checksum at the end of a line, never emitted
    localparam int TAIL_BYTES = 2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_LOAD
    } t_state;

endpackage

/* rtl/core/teleinfo_line_framer.sv */
`timescale 1ns / 1ps

// teleinfo line framer
// input channel s_axis: one raw serial byte per item, bit 7 (parity) is ignored.
// output channel m_axis: one seven-bit byte per item; tuser marks an stx/etx
// marker, tlast marks the final byte of a run.
// stx and etx go straight to the output as single-item runs with tlast set.
// lf opens a line and sets the stored length to zero, further bytes are
// written to the store, a full store drops the line. cr closes the line and,
// when more than two bytes were stored, sends all but the last two as one run.
// outside a run a byte is taken whenever the output register is free; a marker
// shows on m_axis the cycle after. a cr that closes a line of L stored bytes
// starts a run of L-2 items that are read from the single-port line store,
// each in two steps (the registered memory read, then the load of the output
// register), and the input is held off until the last item is loaded.
// reset clears the line state and the output register; the store contents
// need no clearing, only entries written since the last lf are read.
// when the receiver stalls, the result waits in the output register and the
// block takes no new input item until that register is free.
module teleinfo_line_framer #(
    parameter int LINE_DEPTH = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input channel
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    // output channel
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [6:0] out_byte, [7] zero fill
    output logic       m_axis_tuser,   // [0] is_marker
    output logic       m_axis_tlast    // last
);

    localparam int IW = $clog2(LINE_DEPTH);      // store index width
    localparam int LW = $clog2(LINE_DEPTH + 1);  // line length width

    // control state
    tlf_pkg::t_state r_state, n_state;
    logic [LW-1:0]   r_len, n_len;
    logic            r_open, n_open;
    logic [IW-1:0]   r_idx, n_idx;   // store entry being emitted
    logic [IW-1:0]   r_end, n_end;   // index of the last entry of the run

    // output register
    logic            r_out_valid, n_out_valid;
    logic [6:0]      r_out_byte;
    logic            r_out_marker;
    logic            r_out_last;

    // line store, one write or one read per cycle
    logic [6:0]      r_mem [LINE_DEPTH];
    logic [6:0]      r_rd_data;

    logic            w_in_acc;
    logic [6:0]      w_b;
    logic            w_is_mrk;
    logic            w_is_cr;
    logic            w_is_lf;
    logic            w_out_free;
    logic            w_ready;
    logic            w_wr_en;
    logic            w_rd_en;
    logic            w_load;

    assign w_b        = s_axis_tdata[6:0] & tlf_pkg::BYTE_MASK;
    assign w_is_mrk   = w_b inside {tlf_pkg::CODE_STX, tlf_pkg::CODE_ETX};
    assign w_is_cr    = (w_b == tlf_pkg::CODE_CR);
    assign w_is_lf    = (w_b == tlf_pkg::CODE_LF);
    assign w_out_free = !r_out_valid || m_axis_tready;
    // input is taken only outside a run
    assign w_ready    = (r_state == tlf_pkg::S_IDLE) && w_out_free;
    assign w_in_acc   = s_axis_tvalid && w_ready;

    // next state and control
    always_comb begin
        n_state = r_state;
        n_len   = r_len;
        n_open  = r_open;
        n_idx   = r_idx;
        n_end   = r_end;
        w_wr_en = 1'b0;
        w_rd_en = 1'b0;
        w_load  = 1'b0;
        case (r_state)
            tlf_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    if (w_is_mrk) begin
                        // markers go to the output register, line untouched
                    end else if (w_is_cr) begin
                        if (r_open && (r_len > LW'(tlf_pkg::TAIL_BYTES))) begin
                            n_state = tlf_pkg::S_READ;
                            n_idx   = '0;
                            n_end   = IW'(r_len - LW'(tlf_pkg::TAIL_BYTES + 1));
                        end
                        n_open = 1'b0;
                        n_len  = '0;
                    end else if (w_is_lf) begin
                        n_open = 1'b1;
                        n_len  = '0;
                    end else if (r_open) begin
                        if (r_len < LW'(LINE_DEPTH)) begin
                            w_wr_en = 1'b1;
                            n_len   = r_len + LW'(1);
                        end else begin
                            // store full: drop the line
                            n_open = 1'b0;
                        end
                    end
                end
            end
            tlf_pkg::S_READ: begin
                w_rd_en = 1'b1;
                n_state = tlf_pkg::S_LOAD;
            end
            tlf_pkg::S_LOAD: begin
                if (w_out_free) begin
                    w_load = 1'b1;
                    if (r_idx == r_end) begin
                        n_state = tlf_pkg::S_IDLE;
                    end else begin
                        n_idx   = r_idx + IW'(1);
                        n_state = tlf_pkg::S_READ;
                    end
                end
            end
            default: begin
                n_state = tlf_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid && !m_axis_tready;
        if (w_load || (w_in_acc && w_is_mrk)) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tlf_pkg::S_IDLE;
            r_len       <= '0;
            r_open      <= 1'b0;
            r_idx       <= '0;
            r_end       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_len       <= n_len;
            r_open      <= n_open;
            r_idx       <= n_idx;
            r_end       <= n_end;
            r_out_valid <= n_out_valid;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_byte   <= r_rd_data;
            r_out_marker <= 1'b0;
            r_out_last   <= (r_idx == r_end);
        end else if (w_in_acc && w_is_mrk) begin
            r_out_byte   <= w_b;
            r_out_marker <= 1'b1;
            r_out_last   <= 1'b1;
        end
    end

    // line store
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_len[IW-1:0]] <= w_b;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[r_idx];
        end
    end

    assign s_axis_tready = w_ready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out_byte};
    assign m_axis_tuser  = r_out_marker;
    assign m_axis_tlast  = r_out_last;

    // checks

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LW'(LINE_DEPTH))
        else $error("line length beyond store depth");

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != tlf_pkg::S_IDLE) |-> (r_idx <= r_end))
        else $error("emit index past end of run");

    a_marker_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && w_is_mrk) |=> (m_axis_tvalid && m_axis_tuser && m_axis_tlast))
        else $error("marker not presented after acceptance");

    a_run_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && w_is_cr && r_open && (r_len > LW'(tlf_pkg::TAIL_BYTES)))
        |=> (r_state == tlf_pkg::S_READ && !r_open && r_len == '0))
        else $error("closing cr did not start a run");

    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && (r_idx == r_end))
        |=> (r_state == tlf_pkg::S_IDLE && m_axis_tvalid && m_axis_tlast && !m_axis_tuser))
        else $error("run end not marked");

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps

module testbench;

    localparam int LINE_DEPTH   = 64;
    localparam int RANDOM_ITEMS = 150;
    localparam int CLK_HALF     = 6;
    // a full line holds the input off while its items are sent out
    localparam int DRAIN_CYCLES = 2 * LINE_DEPTH + 16;

    typedef struct packed {
        logic [6:0] out_byte;
        logic       is_marker;
        logic       last;
    } t_line_item;

    // tracks the line state of the framer and the items it still owes
    class line_scoreboard;
        logic [6:0]  line_bytes [LINE_DEPTH];
        int unsigned line_len;
        bit          line_open;
        t_line_item  owed_items [$];
        int          errors;
        int          items_checked;
        int          lines_sent;
        int          markers_sent;
        int          lines_dropped;

        // returns 1 unless the byte is ignored outside a line
        function bit take_byte(input logic [7:0] raw);
            logic [6:0]  b;
            t_line_item  item;
            int unsigned n;
            b = raw[6:0];
            if (b == tlf_pkg::CODE_STX || b == tlf_pkg::CODE_ETX) begin
                item.out_byte  = b;
                item.is_marker = 1'b1;
                item.last      = 1'b1;
                owed_items.push_back(item);
                markers_sent++;
                return 1'b1;
            end
            if (b == tlf_pkg::CODE_CR) begin
                // separator and checksum at the tail are never sent
                if (line_open && line_len > tlf_pkg::TAIL_BYTES) begin
                    n = line_len - tlf_pkg::TAIL_BYTES;
                    for (int unsigned k = 0; k < n; k++) begin
                        item.out_byte  = line_bytes[k];
                        item.is_marker = 1'b0;
                        item.last      = (k + 1 == n);
                        owed_items.push_back(item);
                    end
                    lines_sent++;
                end
                line_open = 1'b0;
                line_len  = 0;
                return 1'b1;
            end
            if (b == tlf_pkg::CODE_LF) begin
                line_open = 1'b1;
                line_len  = 0;
                return 1'b1;
            end
            if (!line_open)
                return 1'b0;
            if (line_len < LINE_DEPTH) begin
                line_bytes[line_len] = b;
                line_len++;
            end else begin
                // one byte too many drops the whole line
                line_open = 1'b0;
                lines_dropped++;
            end
            return 1'b1;
        endfunction

        function void check_out_item(input logic [7:0] data, input logic user,
                                     input logic last);
            t_line_item want;
            if (owed_items.size() == 0) begin
                $display("%0t: unexpected item data=%h user=%b last=%b",
                         $time, data, user, last);
                errors++;
                return;
            end
            want = owed_items.pop_front();
            items_checked++;
            if (data[6:0] != want.out_byte || data[7] != 1'b0) begin
                $display("%0t: out_byte expected %h actual %h", $time,
                         {1'b0, want.out_byte}, data);
                errors++;
            end
            if (user != want.is_marker) begin
                $display("%0t: is_marker expected %b actual %b", $time,
                         want.is_marker, user);
                errors++;
            end
            if (last != want.last) begin
                $display("%0t: last expected %b actual %b", $time, want.last, last);
                errors++;
            end
        endfunction

        function int owed();
            return owed_items.size();
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;
    logic       m_axis_tuser;
    logic       m_axis_tlast;

    line_scoreboard sb = new();

    int  sent_items;
    int  counted_items;
    bit  in_burst;
    bit  out_burst;
    int  out_stall;

    // bytes outside a line, a line with a marker inside, a short line,
    // a line that sends one byte and a line restarted by a second lf
    logic [7:0] opening_seq [$] = '{
        8'h41, 8'hff, {1'b0, tlf_pkg::CODE_CR}, {1'b0, tlf_pkg::CODE_STX},
        {1'b1, tlf_pkg::CODE_ETX},
        {1'b1, tlf_pkg::CODE_LF}, 8'h00, 8'h7f, {1'b1, tlf_pkg::CODE_STX}, 8'hc1,
        8'h20, {1'b1, tlf_pkg::CODE_CR},
        {1'b0, tlf_pkg::CODE_LF}, 8'h31, 8'h32, {1'b0, tlf_pkg::CODE_CR},
        {1'b0, tlf_pkg::CODE_LF}, 8'hb1, 8'h32, 8'h33, {1'b0, tlf_pkg::CODE_CR},
        {1'b0, tlf_pkg::CODE_LF}, 8'h55, {1'b1, tlf_pkg::CODE_LF}, 8'h41, 8'h42,
        8'he3, {1'b0, tlf_pkg::CODE_CR}
    };

    teleinfo_line_framer #(
        .LINE_DEPTH(LINE_DEPTH)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic logic [7:0] payload_byte();
        logic [6:0] v;
        v = 7'($urandom_range(0, 127));
        while (v == tlf_pkg::CODE_STX || v == tlf_pkg::CODE_ETX ||
               v == tlf_pkg::CODE_CR || v == tlf_pkg::CODE_LF)
            v = 7'($urandom_range(0, 127));
        return {1'($urandom_range(0, 1)), v};
    endfunction

    function automatic logic [7:0] marker_byte();
        return {1'($urandom_range(0, 1)),
                ($urandom_range(0, 1) ? tlf_pkg::CODE_STX : tlf_pkg::CODE_ETX)};
    endfunction

    // valid is only lowered when a gap follows, so it never drops and
    // rises again within one step
    task automatic send_byte(input logic [7:0] raw);
        int gap;
        gap = in_burst ? 0 : $urandom_range(0, 7);
        if ($urandom_range(0, 15) == 0)
            in_burst = !in_burst;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= raw;
        do @(posedge i_clk); while (!s_axis_tready);
        if (sb.take_byte(raw))
            counted_items++;
        sent_items++;
    endtask

    // hold the input until every owed item has come out
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.owed() > 0);
    endtask

    task automatic send_line(input int unsigned n_bytes, input bit close_it);
        int unsigned marker_at;
        marker_at = ($urandom_range(0, 4) == 0) ? $urandom_range(0, n_bytes) : n_bytes;
        send_byte({1'($urandom_range(0, 1)), tlf_pkg::CODE_LF});
        for (int unsigned k = 0; k < n_bytes; k++) begin
            if (k == marker_at)
                send_byte(marker_byte());
            send_byte(payload_byte());
        end
        if (close_it)
            send_byte({1'($urandom_range(0, 1)), tlf_pkg::CODE_CR});
    endtask

    // output side: check every accepted item, then stall for a drawn count
    initial begin
        m_axis_tready <= 1'b0;
        out_stall = 0;
        out_burst = 1'b0;
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) begin
                sb.check_out_item(m_axis_tdata, m_axis_tuser, m_axis_tlast);
                out_stall = out_burst ? 0 : $urandom_range(0, 7);
                if ($urandom_range(0, 15) == 0)
                    out_burst = !out_burst;
            end
            if (out_stall > 0) begin
                m_axis_tready <= 1'b0;
                out_stall--;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin
        int          start_count;
        int          line_no;
        int          pick;
        int unsigned n_bytes;
        bit          close_it;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        sent_items    = 0;
        counted_items = 0;
        in_burst      = 1'b0;
        line_no       = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (opening_seq[i])
            send_byte(opening_seq[i]);
        wait_drained();

        // mostly well-formed lines with random content, some noise and
        // lines left without cr
        start_count = counted_items;
        while (counted_items - start_count < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                close_it = ($urandom_range(0, 9) != 0);
                if (line_no == 1) begin
                    n_bytes  = LINE_DEPTH;
                    close_it = 1'b1;
                end else if (line_no == 3) begin
                    n_bytes  = LINE_DEPTH + 1 + $urandom_range(0, 2);
                    close_it = 1'b1;
                end else if ($urandom_range(0, 9) == 0) begin
                    n_bytes = $urandom_range(LINE_DEPTH - 4, LINE_DEPTH + 2);
                end else begin
                    n_bytes = $urandom_range(0, 14);
                end
                send_line(n_bytes, close_it);
                // full line: let the whole run come out before going on
                if (line_no == 1)
                    wait_drained();
                line_no++;
            end else if (pick < 80) begin
                send_byte(marker_byte());
            end else begin
                repeat ($urandom_range(1, 4))
                    send_byte(8'($urandom_range(0, 255)));
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.owed() > 0) begin
            $display("%0t: %0d items still owed at the end", $time, sb.owed());
            sb.errors++;
        end
        $display("run covered %0d bytes sent (%0d not ignored), %0d items checked",
                 sent_items, counted_items, sb.items_checked);
        $display("  %0d lines sent out, %0d markers, %0d lines dropped on a full store",
                 sb.lines_sent, sb.markers_sent, sb.lines_dropped);
        if (sb.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/core/tlf_pkg.sv
rtl/core/teleinfo_line_framer.sv
verif/testbench.sv
